// ===== src/usam_pkg.sv =====
package usam_pkg;

	// Fixed field widths of the channels
	localparam int IN_W  = 16;
	localparam int OUT_W = 32;

	// Data one cell hands down to its lower neighbor each round
	typedef struct packed {
		logic sum;  // accumulator bit after the conditional add
		logic q;    // multiplier register bit
	} link_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic load;  // capture operands, clear accumulator
		logic step;  // perform one add-and-shift round
		logic add;   // low bit of Q: add multiplicand this round
	} ctl_t;

endpackage

// ===== src/usam_in_if.sv =====
interface usam_in_if;
	logic                       valid;
	logic                       ready;
	logic [usam_pkg::IN_W-1:0]  multiplicand;
	logic [usam_pkg::IN_W-1:0]  multiplier;

	modport source (output valid, output multiplicand, output multiplier, input ready);
	modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

// ===== src/usam_out_if.sv =====
interface usam_out_if;
	logic                       valid;
	logic                       ready;
	logic [usam_pkg::OUT_W-1:0] product;

	modport source (output valid, output product, input ready);
	modport sink   (input valid, input product, output ready);
endinterface

// ===== src/unsigned_shift_add_multiplier.sv =====
// Unsigned shift-add multiplier. An item carries two unsigned operands whose
// low WIDTH bits take part (bits above WIDTH are ignored, missing bits read
// as zero); the result is the 2*WIDTH-bit product A:Q, truncated to its low
// 32 bits when WIDTH exceeds 16. The datapath is a row of WIDTH identical bit
// cells; each cell holds one bit of the accumulator A, the multiplier
// register Q and the multiplicand M, and the row performs one add-and-shift
// round per clock: the multiplicand is added into A when Q's low bit is one
// (a ripple carry runs through the row), then carry, A and Q move one cell
// down, with A's low bit entering the top of Q. An item goes from the input
// transfer to the result in the output register as follows: the transfer
// edge itself loads the row, WIDTH rounds follow, and a hand-over moves the
// product out. The input is ready again only in the cycle after that
// hand-over, so a new item is taken only once the previous one has left the
// cell row. A finished product waits in the output register, so the next
// item may be taken while the previous result has not yet been
// transferred; a product that cannot move out holds the row and the input.
// Nothing is kept between items.
module unsigned_shift_add_multiplier #(
	parameter int WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	usam_in_if.sink     in_ch,
	usam_out_if.source  out_ch
);

	localparam int CW     = $clog2(WIDTH + 1);
	localparam int PROD_W = 2 * WIDTH;

	// Control
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic [usam_pkg::OUT_W-1:0] product_q;

	logic in_xfer;
	logic rounds_done;
	logic move_out;

	usam_pkg::ctl_t ctl;

	// Row wiring
	logic [WIDTH-1:0]     mcand_w;
	logic [WIDTH-1:0]     mplier_w;
	logic [WIDTH:0]       carry;
	usam_pkg::link_t      link   [WIDTH];
	usam_pkg::link_t      upper  [WIDTH];
	logic [WIDTH-1:0]     a_row;
	logic [WIDTH-1:0]     q_row;
	logic [PROD_W-1:0]    full_prod;
	logic [usam_pkg::OUT_W-1:0] prod_fit;

	assign in_ch.ready = ~busy_q;
	assign in_xfer     = in_ch.valid & ~busy_q;
	assign rounds_done = (cnt_q == CW'(WIDTH));
	// hand the product over once the output register is free or draining
	assign move_out    = busy_q & rounds_done & (~out_valid_q | out_ch.ready);

	assign ctl.load = in_xfer;
	assign ctl.step = busy_q & ~rounds_done;
	assign ctl.add  = q_row[0];

	// Fit operand fields to WIDTH bits
	generate
		if (WIDTH <= usam_pkg::IN_W) begin : g_op_trunc
			assign mcand_w  = in_ch.multiplicand[WIDTH-1:0];
			assign mplier_w = in_ch.multiplier[WIDTH-1:0];
		end else begin : g_op_ext
			assign mcand_w  = {{(WIDTH - usam_pkg::IN_W){1'b0}}, in_ch.multiplicand};
			assign mplier_w = {{(WIDTH - usam_pkg::IN_W){1'b0}}, in_ch.multiplier};
		end
	endgenerate

	// Carry ripples upward from cell 0; no carry enters the bottom
	assign carry[0] = 1'b0;

	generate
		for (genvar i = 0; i < WIDTH; i++) begin : g_cell
			// top cell takes the final carry into A and cell 0's sum into Q
			if (i == WIDTH - 1) begin : g_top
				assign upper[i].sum = carry[WIDTH];
				assign upper[i].q   = link[0].sum;
			end else begin : g_mid
				assign upper[i] = link[i+1];
			end

			usam_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.mcand_bit  (mcand_w[i]),
				.mplier_bit (mplier_w[i]),
				.carry_in   (carry[i]),
				.upper      (upper[i]),
				.carry_out  (carry[i+1]),
				.link       (link[i]),
				.a_bit      (a_row[i])
			);

			assign q_row[i] = link[i].q;
		end
	endgenerate

	// Product is A in the high half, Q in the low half
	assign full_prod = {a_row, q_row};

	generate
		if (PROD_W >= usam_pkg::OUT_W) begin : g_prod_trunc
			assign prod_fit = full_prod[usam_pkg::OUT_W-1:0];
		end else begin : g_prod_ext
			assign prod_fit = {{(usam_pkg::OUT_W - PROD_W){1'b0}}, full_prod};
		end
	endgenerate

	// Sequencer: hold busy from load until the product moves out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (in_xfer) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (move_out) begin
			busy_q <= 1'b0;
		end
	end

	// Output register: drop valid on transfer, load on hand-over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_out) begin
			product_q <= prod_fit;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.product = product_q;

endmodule

// ===== src/usam_cell.sv =====
// One bit slice: holds A[i], Q[i] and M[i], adds with ripple carry,
// and takes its next A and Q bits from the neighbor above.
module usam_cell (
	input  logic            clk,
	input  usam_pkg::ctl_t  ctl,
	input  logic            mcand_bit,
	input  logic            mplier_bit,
	input  logic            carry_in,
	input  usam_pkg::link_t upper,
	output logic            carry_out,
	output usam_pkg::link_t link,
	output logic            a_bit
);

	logic a_q;
	logic q_q;
	logic m_q;
	logic addend;

	assign addend    = m_q & ctl.add;
	assign link.sum  = a_q ^ addend ^ carry_in;
	assign link.q    = q_q;
	assign carry_out = (a_q & addend) | (carry_in & (a_q ^ addend));
	assign a_bit     = a_q;

	// Operand bits are payload: no reset needed
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= 1'b0;
			q_q <= mplier_bit;
			m_q <= mcand_bit;
		end else if (ctl.step) begin
			// shift right as one word: take the upper neighbor's bits
			a_q <= upper.sum;
			q_q <= upper.q;
		end
	end

endmodule

// ===== tb/sv/tb_unsigned_shift_add_multiplier.sv =====
`timescale 1ns / 1ps

module tb_unsigned_shift_add_multiplier;

	// Field widths of the channels
	localparam int IN_W  = usam_pkg::IN_W;
	localparam int OUT_W = usam_pkg::OUT_W;

	// Operand width of the instance under test
	localparam int WIDTH = IN_W;
	// Cycles from input transfer to the product sitting in the output register
	localparam int LATENCY = WIDTH + 1;
	localparam int RANDOM_ITEMS = 1600;
	// Receiver hold-off for the backpressure test; far longer than a few items take
	localparam int LONG_HOLD_CYCLES = 400;
	// Allow several times the slowest correct run of roughly 1650 items with the
	// latency and the longest gaps on both sides.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	logic clk;
	logic arst_n;

	usam_in_if  in_ch ();
	usam_out_if out_ch ();

	unsigned_shift_add_multiplier #(
		.WIDTH(WIDTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Products still owed by the block, oldest first
	logic [OUT_W-1:0] expected_products[$];

	int unsigned error_count;
	int unsigned items_sent;
	int unsigned products_checked;
	int unsigned cycle_count;

	// Idling controls: the tests switch these to get stretches with and without gaps
	bit src_idle_en;
	bit sink_idle_en;
	bit long_hold_req;
	int unsigned sink_stall_left;

	// Free-running clock, 10 ns period
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Drive every input to a known value from time zero
	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.multiplicand <= '0;
		in_ch.multiplier <= '0;
		out_ch.ready <= 1'b0;
	end

	// Shift-add product: C, A, Q registers, WIDTH add-and-shift rounds
	function automatic logic [OUT_W-1:0] shift_add_product(
		input logic [IN_W-1:0] mcand,
		input logic [IN_W-1:0] mplier
	);
		logic [WIDTH-1:0] acc;
		logic [WIDTH-1:0] qreg;
		logic [WIDTH-1:0] mreg;
		logic [WIDTH:0]   sum;
		logic             carry;
		acc  = '0;
		qreg = mplier[WIDTH-1:0];
		mreg = mcand[WIDTH-1:0];
		for (int r = 0; r < WIDTH; r++) begin
			carry = 1'b0;
			if (qreg[0]) begin
				sum   = {1'b0, acc} + {1'b0, mreg};
				carry = sum[WIDTH];
				acc   = sum[WIDTH-1:0];
			end
			// Carry enters the top of A, the low bit of A enters the top of Q
			{acc, qreg} = {carry, acc, qreg[WIDTH-1:1]};
		end
		return OUT_W'({acc, qreg});
	endfunction

	// Gap length: mostly a few cycles, now and then a long one
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// Operand drawn from a mix of shapes so that carries, zeros and
	// single bits all show up often
	function automatic logic [IN_W-1:0] pick_operand();
		logic [IN_W-1:0] v;
		int unsigned     sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			v = IN_W'($urandom);
		else if (sel < 55)
			v = IN_W'($urandom_range(0, 15));
		else if (sel < 70)
			v = {IN_W{1'b1}} - IN_W'($urandom_range(0, 15));
		else if (sel < 80)
			v = IN_W'(1) << $urandom_range(0, IN_W - 1);
		else if (sel < 88)
			v = IN_W'($urandom_range(0, 1));
		else if (sel < 94)
			v = IN_W'($urandom & $urandom);
		else
			v = IN_W'($urandom | $urandom);
		return v;
	endfunction

	// Offer one operand pair and hold it until the block takes it.
	// Call at a rising edge; valid stays high so back-to-back sends do not
	// drop it in between.
	task automatic send_operands(input logic [IN_W-1:0] mcand, input logic [IN_W-1:0] mplier);
		in_ch.multiplicand <= mcand;
		in_ch.multiplier <= mplier;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		expected_products.push_back(shift_add_product(mcand, mplier));
		items_sent++;
	endtask

	// Maybe drop valid for a while, with junk on the payload
	task automatic source_gap();
		int unsigned n;
		if (src_idle_en && $urandom_range(0, 99) < 30) begin
			n = pick_gap();
			in_ch.valid <= 1'b0;
			in_ch.multiplicand <= IN_W'($urandom);
			in_ch.multiplier <= IN_W'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every owed product has been transferred
	task automatic wait_products_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_products.size() != 0)
			@(posedge clk);
	endtask

	// Extremes of both operands and carry-heavy patterns
	task automatic test_directed_corners();
		logic [IN_W-1:0] corner_a[] = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
			16'h0001, 16'h0001, 16'hFFFF, 16'h8000, 16'h8000, 16'h0001, 16'hAAAA,
			16'h5555, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h8001, 16'h00FF, 16'hFF00};
		logic [IN_W-1:0] corner_b[] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
			16'h0001, 16'hFFFF, 16'h0001, 16'h8000, 16'h0001, 16'h8000, 16'h5555,
			16'hAAAA, 16'h7FFF, 16'h8000, 16'hFFFE, 16'h8001, 16'hFF00, 16'h00FF};
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		foreach (corner_a[i])
			send_operands(corner_a[i], corner_b[i]);
		wait_products_drained();
	endtask

	// No gaps on either side: items go in at the block's full rate
	task automatic test_back_to_back();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		repeat (40)
			send_operands(pick_operand(), pick_operand());
		wait_products_drained();
	endtask

	// Hold the receiver off while the sender keeps offering, so the output
	// register fills and the input stalls; then let it all drain
	task automatic test_output_backpressure();
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		long_hold_req = 1'b1;
		repeat (10)
			send_operands(pick_operand(), pick_operand());
		wait_products_drained();
	endtask

	// Bulk random operands with random idling on both sides; the sender
	// pauses for a full drain now and then
	task automatic test_random_products();
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			source_gap();
			send_operands(pick_operand(), pick_operand());
			// Switch idling off for stretches, and drain once in a while
			if (i % 200 == 100) begin
				src_idle_en = 1'b0;
				sink_idle_en = 1'b0;
			end else if (i % 200 == 140) begin
				src_idle_en = 1'b1;
				sink_idle_en = 1'b1;
			end
			if (i % 400 == 399)
				wait_products_drained();
		end
		wait_products_drained();
	endtask

	// Receiver: random stalls, plus one long hold-off when a test asks for it
	initial begin
		sink_stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
			end else if (sink_stall_left != 0) begin
				out_ch.ready <= 1'b0;
				sink_stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (sink_idle_en && $urandom_range(0, 99) < 12)
					sink_stall_left = pick_gap();
			end
		end
	end

	// Check every transferred product against the oldest expectation
	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_products.size() == 0) begin
				$display("%0t: unexpected product: expected none, actual %h",
					$time, out_ch.product);
				error_count++;
			end else begin
				want = expected_products.pop_front();
				products_checked++;
				if (out_ch.product !== want) begin
					$display("%0t: product mismatch: expected %h, actual %h",
						$time, want, out_ch.product);
					error_count++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d products outstanding",
				$time, cycle_count, expected_products.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		items_sent = 0;
		products_checked = 0;
		cycle_count = 0;
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		long_hold_req = 1'b0;

		// Hold reset, then release it away from the rising edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_back_to_back();
		test_output_backpressure();
		test_random_products();

		// Let any stray result show up before closing
		repeat (4 * LATENCY) @(posedge clk);
		if (expected_products.size() != 0) begin
			$display("%0t: %0d products never arrived", $time, expected_products.size());
			error_count++;
		end

		$display("Covered corner operands, full-rate transfers, a long output hold-off");
		$display("and random idling: %0d operand pairs sent, %0d products checked",
			items_sent, products_checked);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
